// ===== sv/itra_pkg.sv =====
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants, the digit to ASCII mapping and radix saturation
// for the integer to radix text converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned RadixBits  = 6;
  localparam int unsigned CharBits   = 7;

  localparam logic [RadixBits-1:0] RadixMin   = 6'd2;
  localparam logic [RadixBits-1:0] RadixMax   = 6'd36;
  localparam logic [RadixBits-1:0] RadixReset = 6'd10;

  localparam logic [CharBits-1:0] MinusCode   = 7'h2d;
  localparam logic [CharBits-1:0] ZeroCode    = 7'h30;
  localparam logic [CharBits-1:0] LowerACode  = 7'h61;
  localparam logic [RadixBits-1:0] DecDigits  = 6'd10;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } itra_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } itra_stack_ctl_t;

  function automatic logic [CharBits-1:0] digit_to_ascii(logic [RadixBits-1:0] d);
    logic [CharBits-1:0] code;
    if (d < DecDigits) begin
      code = ZeroCode + {1'b0, d};
    end else begin
      code = LowerACode + {1'b0, d} - {1'b0, DecDigits};
    end
    return code;
  endfunction

  function automatic logic [RadixBits-1:0] saturate_radix(logic [RadixBits-1:0] r);
    logic [RadixBits-1:0] res;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

// ===== sv/itra_value_if.sv =====
// ----------------------------------------------------------------------------
// itra_value_if
// Input channel: one signed integer per transfer.
// ----------------------------------------------------------------------------
interface itra_value_if #(
  parameter int unsigned VALUE_BITS = itra_pkg::ValueBits
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== sv/itra_char_if.sv =====
// ----------------------------------------------------------------------------
// itra_char_if
// Output channel: one ASCII character per transfer with an end marker.
// ----------------------------------------------------------------------------
interface itra_char_if;
  logic                              valid;
  logic                              ready;
  logic [itra_pkg::CharBits-1:0]     character;
  logic                              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

// ===== sv/itra_cfg_if.sv =====
// ----------------------------------------------------------------------------
// itra_cfg_if
// Configuration write channel carrying the radix.
// ----------------------------------------------------------------------------
interface itra_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [itra_pkg::RadixBits-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

// ===== sv/itra_digit_stack.sv =====
// ----------------------------------------------------------------------------
// itra_digit_stack
// Last-in first-out shift stack for digits; the top entry is always at the
// front, so digits pushed least significant first pop most significant first.
// ----------------------------------------------------------------------------
module itra_digit_stack #(
  parameter int unsigned DEPTH = itra_pkg::ValueBits
) (
  input  logic                            clk_i,
  input  itra_pkg::itra_stack_ctl_t       ctl_i,
  input  logic [itra_pkg::RadixBits-1:0]  digit_i,
  output logic [itra_pkg::RadixBits-1:0]  top_o
);

  logic [itra_pkg::RadixBits-1:0] entry_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q[0] <= digit_i;
      for (int k = 1; k < DEPTH; k++) begin
        entry_q[k] <= entry_q[k-1];
      end
    end else if (ctl_i.pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        entry_q[k] <= entry_q[k+1];
      end
    end
  end

  assign top_o = entry_q[0];

endmodule

// ===== sv/integer_to_radix_ascii_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// Converts a signed integer to its ASCII text in a programmable radix,
// most significant character first, with a leading minus for negatives.
//
//   channel  dir  payload               transfer when
//   cfg_i    in   radix (6b)            valid && ready (ready always high)
//   in_i     in   value (VALUE_BITS)    valid && ready
//   out_o    out  character, last_char  valid && ready
//
// each digit is computed on the shared restoring-division subtractor,
// one quotient bit per cycle, and pushed on the digit stack
// characters (sign plus digits) then go out one per cycle while the
// output side keeps up
// output stalls hold the character register and pause emission
// reset sets radix to 10 and returns the sequencer to idle
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top #(
  parameter int unsigned VALUE_BITS = itra_pkg::ValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itra_cfg_if.sink    cfg_i,
  itra_value_if.sink  in_i,
  itra_char_if.source out_o
);

  localparam int unsigned BitW = $clog2(VALUE_BITS);
  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);
  localparam int unsigned RW   = itra_pkg::RadixBits;
  localparam int unsigned CW   = itra_pkg::CharBits;

  itra_pkg::itra_state_e state_q, state_d;

  logic [RW-1:0]         radix_q;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [BitW-1:0]       bit_q, bit_d;
  logic [CntW-1:0]       ndig_q, ndig_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [CW-1:0]         out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [VALUE_BITS-1:0] raw;
  logic [RW:0]           trial;
  logic [RW:0]           diff;
  logic                  fits;
  logic [RW-1:0]         rem_step;
  logic [RW-1:0]         top_digit;
  logic                  in_ready;
  itra_pkg::itra_stack_ctl_t stack_ctl;

  // radix register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itra_pkg::RadixReset;
    end else if (cfg_i.valid) begin
      radix_q <= itra_pkg::saturate_radix(cfg_i.radix);
    end
  end

  // shared subtractor
  assign raw      = in_i.value;
  assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, radix_q};
  assign fits     = (trial >= {1'b0, radix_q});
  assign rem_step = fits ? diff[RW-1:0] : trial[RW-1:0];

  itra_digit_stack #(
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk_i   (clk_i),
    .ctl_i   (stack_ctl),
    .digit_i (rem_step),
    .top_o   (top_digit)
  );

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    stack_ctl   = '0;
    in_ready    = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      itra_pkg::StIdle: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          neg_d   = raw[VALUE_BITS-1];
          mag_d   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          rem_d   = '0;
          bit_d   = '0;
          ndig_d  = '0;
          state_d = itra_pkg::StDiv;
        end
      end
      itra_pkg::StDiv: begin
        rem_d = rem_step;
        mag_d = {mag_q[VALUE_BITS-2:0], fits};
        bit_d = bit_q + BitW'(1);
        if (bit_q == BitW'(VALUE_BITS - 1)) begin
          stack_ctl.push = 1'b1;
          ndig_d = ndig_q + CntW'(1);
          rem_d  = '0;
          bit_d  = '0;
          if ((mag_d == '0) || (ndig_q == CntW'(VALUE_BITS - 1))) begin
            state_d = itra_pkg::StEmit;
          end
        end
      end
      itra_pkg::StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_char_d = itra_pkg::MinusCode;
            out_last_d = 1'b0;
            neg_d      = 1'b0;
          end else begin
            out_char_d    = itra_pkg::digit_to_ascii(top_digit);
            out_last_d    = (ndig_q == CntW'(1));
            stack_ctl.pop = 1'b1;
            ndig_d        = ndig_q - CntW'(1);
            if (ndig_q == CntW'(1)) begin
              state_d = itra_pkg::StIdle;
            end
          end
        end
      end
      default: begin
        state_d = itra_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itra_pkg::StIdle;
      bit_q       <= '0;
      ndig_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      ndig_q      <= ndig_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last_char = out_last_q;

endmodule

// ===== sv/itra_checker.sv =====
// ----------------------------------------------------------------------------
// itra_checker
// Port-level checks for the integer to radix text converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module itra_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [itra_pkg::CharBits-1:0] out_char_i,
  input logic                          out_last_i
);

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while busy");

  // stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_char_i) && $stable(out_last_i)))
    else $error("stalled character changed");

  // a minus sign never ends a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_char_i == itra_pkg::MinusCode)) |-> !out_last_i)
    else $error("minus marked as last");

  // back to idle only with the final character loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> (out_valid_i && out_last_i))
    else $error("idle without final character");

endmodule

bind integer_to_radix_ascii_top itra_checker u_itra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last_char)
);
